// ----- src/cosp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cosp_pkg
// Shared types, binary32 constants and helper functions for the cosine
// pipeline and its fused multiply-add units.
// ---------------------------------------------------------------------------
package cosp_pkg;

  // Register stages in one fused multiply-add unit.
  localparam int FMA_LAT = 7;
  // Dependent floating-point operations in the cosine datapath.
  localparam int NUM_OPS = 13;

  // Signed working exponent, wide enough for products of subnormals.
  typedef logic signed [10:0] exp_t;

  typedef struct packed {
    logic        sgn;
    logic        zero;
    logic        inf;
    logic        nan;
    exp_t        ex;
    logic [23:0] man;
  } unp_t;

  localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
  localparam logic [31:0] ONE_BITS   = 32'h3F800000;
  localparam logic [31:0] NEG_ZERO   = 32'h80000000;
  localparam logic [30:0] RANGE_BITS = 31'h49800000;

  localparam logic [31:0] HALF_PI    = 32'h3FC90FDB;
  localparam logic [31:0] INV_PI     = 32'h3EA2F983;
  localparam logic [31:0] SHIFT_C    = 32'h4B400000;
  localparam logic [31:0] NEG_SHIFT  = 32'hCB400000;
  localparam logic [31:0] NEG_HALF   = 32'hBF000000;
  localparam logic [31:0] NEG_PI_HI  = 32'hC0490FDB;
  localparam logic [31:0] NEG_PI_MID = 32'h33BBBD2E;
  localparam logic [31:0] NEG_PI_LO  = 32'h27772CED;
  localparam logic [31:0] POLY_C0    = 32'hBE2AAAA4;
  localparam logic [31:0] POLY_C1    = 32'h3C0886FA;
  localparam logic [31:0] POLY_C2    = 32'hB94FA175;
  localparam logic [31:0] POLY_C3    = 32'h362D973B;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [6:0] lzc79(input logic [78:0] v);
    logic [6:0] n;
    n = 7'd79;
    for (int i = 0; i < 79; i++) begin
      if (v[i]) n = 7'(78 - i);
    end
    return n;
  endfunction

  // Splits a binary32 word; with norm set, a subnormal significand is
  // shifted up so that its leading one sits at bit 23.
  function automatic unp_t unpack(input logic [31:0] v, input logic norm);
    unp_t       u;
    logic [4:0] lz;
    u.sgn  = v[31];
    u.zero = (v[30:0] == 31'd0);
    u.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    u.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    u.man  = {v[30:23] != 8'h00, v[22:0]};
    u.ex   = (v[30:23] == 8'h00) ? exp_t'(1) : exp_t'({3'b000, v[30:23]});
    lz     = lzc24(u.man);
    if (norm && !u.zero) begin
      u.man = u.man << lz;
      u.ex  = u.ex - exp_t'({6'b000000, lz});
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ----- src/cosp_delay.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cosp_delay
// Fixed-length shift line that keeps operands aligned with the FMA chain.
// ---------------------------------------------------------------------------
module cosp_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 7
) (
  input  wire              clk_i,
  input  wire  [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// ----- src/cosp_fma.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// cosp_fma
// Pipelined binary32 fused multiply-add a*b+c, one rounding, nearest-even.
// Stages: unpack, multiply, align, add, count, normalize, round.
// ---------------------------------------------------------------------------
module cosp_fma
  import cosp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         valid_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  input  wire  [31:0] c_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  logic [FMA_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FMA_LAT-2:0], valid_i};
    end
  end

  // Stage 0: unpack.
  unp_t        ua_q, ub_q, uc_q;
  logic [31:0] c0_q;

  // Stage 1: multiply and special operands.
  logic [47:0] mp1_d, mp1_q;
  exp_t        ep1_d, ep1_q;
  logic        sp1_d, sp1_q;
  unp_t        uc1_q;
  logic        spv1_d, spv1_q;
  logic [31:0] spb1_d, spb1_q;

  always_comb begin
    logic pinf, pzero;
    sp1_d  = ua_q.sgn ^ ub_q.sgn;
    mp1_d  = ua_q.man * ub_q.man;
    ep1_d  = ua_q.ex + ub_q.ex - exp_t'(300);
    pinf   = ua_q.inf | ub_q.inf;
    pzero  = ua_q.zero | ub_q.zero;
    spv1_d = 1'b1;
    spb1_d = QNAN_BITS;
    if (ua_q.nan || ub_q.nan || uc_q.nan || (pinf && pzero) ||
        (pinf && uc_q.inf && (uc_q.sgn != sp1_d))) begin
      spb1_d = QNAN_BITS;
    end else if (pinf) begin
      spb1_d = {sp1_d, 8'hFF, 23'd0};
    end else if (uc_q.inf) begin
      spb1_d = c0_q;
    end else if (pzero) begin
      spb1_d = uc_q.zero ? {sp1_d & uc_q.sgn, 31'd0} : c0_q;
    end else begin
      spv1_d = 1'b0;
    end
  end

  // Stage 2: align the addend against the product.
  logic [77:0] pw2_d, pw2_q, aw2_d, aw2_q;
  exp_t        lw2_d, lw2_q;
  logic        sp2_q, sc2_q;
  logic        spv2_q;
  logic [31:0] spb2_q;

  always_comb begin
    exp_t        k, amt_full;
    logic        clamp;
    logic [6:0]  amt;
    logic [79:0] tc, sh;
    logic        lost;
    k        = uc1_q.ex - ep1_q - exp_t'(147);
    clamp    = (k > exp_t'(54)) && !uc1_q.zero;
    amt_full = exp_t'(56) - k;
    if (k > exp_t'(54)) begin
      amt = 7'd0;
    end else if (amt_full > exp_t'(80)) begin
      amt = 7'd80;
    end else begin
      amt = amt_full[6:0];
    end
    tc   = {uc1_q.man, 56'd0};
    sh   = tc >> amt;
    lost = |(tc & ~({80{1'b1}} << amt));
    if (clamp) begin
      // The whole product lies below the addend's guard bits.
      pw2_d = 78'd1;
      aw2_d = {uc1_q.man, 54'd0};
      lw2_d = uc1_q.ex - exp_t'(204);
    end else begin
      pw2_d = {27'd0, mp1_q, 3'b000};
      aw2_d = {sh[77:1], sh[0] | lost};
      lw2_d = ep1_q - exp_t'(3);
    end
  end

  // Stage 3: signed add.
  logic [78:0] mag3_d, mag3_q;
  logic        sg3_d, sg3_q;
  exp_t        lw3_q;
  logic        spv3_q;
  logic [31:0] spb3_q;

  always_comb begin
    logic [78:0] sum, d1, d2;
    sum = {1'b0, pw2_q} + {1'b0, aw2_q};
    d1  = {1'b0, pw2_q} - {1'b0, aw2_q};
    d2  = {1'b0, aw2_q} - {1'b0, pw2_q};
    if (sp2_q == sc2_q) begin
      mag3_d = sum;
      sg3_d  = sp2_q;
    end else if (!d1[78]) begin
      mag3_d = d1;
      sg3_d  = sp2_q;
    end else begin
      mag3_d = d2;
      sg3_d  = sc2_q;
    end
  end

  // Stage 4: leading-zero count and result exponent.
  logic [78:0] mag4_q;
  exp_t        sl4_d, sl4_q, eo4_d, eo4_q;
  logic        sg4_q, zr4_q;
  logic        spv4_q;
  logic [31:0] spb4_q;

  always_comb begin
    logic [6:0] lz;
    exp_t       e;
    lz = lzc79(mag3_q);
    e  = lw3_q + exp_t'(205) - exp_t'({4'b0000, lz});
    if (e >= exp_t'(1)) begin
      sl4_d = exp_t'({4'b0000, lz});
      eo4_d = e;
    end else begin
      // Subnormal result: line the 2^-149 weight up with the mantissa LSB.
      sl4_d = lw3_q + exp_t'(204);
      eo4_d = '0;
    end
  end

  // Stage 5: normalizing shift.
  logic [23:0] mt5_d, mt5_q;
  logic        g5_d, g5_q, st5_d, st5_q;
  exp_t        eo5_q;
  logic        sg5_q, zr5_q;
  logic        spv5_q;
  logic [31:0] spb5_q;

  always_comb begin
    logic [78:0] nm;
    logic        lost;
    exp_t        rs;
    logic [6:0]  rsa;
    rs  = -sl4_q;
    rsa = (rs > exp_t'(79)) ? 7'd79 : rs[6:0];
    if (!sl4_q[10]) begin
      nm   = mag4_q << sl4_q[6:0];
      lost = 1'b0;
    end else begin
      nm   = mag4_q >> rsa;
      lost = |(mag4_q & ~({79{1'b1}} << rsa));
    end
    mt5_d = nm[78:55];
    g5_d  = nm[54];
    st5_d = (|nm[53:0]) | lost;
  end

  // Stage 6: round and pack.
  logic [31:0] res6_d, res6_q;

  always_comb begin
    logic        rup;
    logic [30:0] packed_w;
    rup      = g5_q & (st5_q | mt5_q[0]);
    packed_w = {eo5_q[7:0], mt5_q[22:0]} + {30'd0, rup};
    if (spv5_q) begin
      res6_d = spb5_q;
    end else if (zr5_q) begin
      res6_d = 32'd0;
    end else if (eo5_q >= exp_t'(255)) begin
      res6_d = {sg5_q, 8'hFF, 23'd0};
    end else begin
      res6_d = {sg5_q, packed_w};
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q   <= unpack(a_i, 1'b1);
    ub_q   <= unpack(b_i, 1'b1);
    uc_q   <= unpack(c_i, 1'b0);
    c0_q   <= c_i;

    mp1_q  <= mp1_d;
    ep1_q  <= ep1_d;
    sp1_q  <= sp1_d;
    uc1_q  <= uc_q;
    spv1_q <= spv1_d;
    spb1_q <= spb1_d;

    pw2_q  <= pw2_d;
    aw2_q  <= aw2_d;
    lw2_q  <= lw2_d;
    sp2_q  <= sp1_q;
    sc2_q  <= uc1_q.sgn;
    spv2_q <= spv1_q;
    spb2_q <= spb1_q;

    mag3_q <= mag3_d;
    sg3_q  <= sg3_d;
    lw3_q  <= lw2_q;
    spv3_q <= spv2_q;
    spb3_q <= spb2_q;

    mag4_q <= mag3_q;
    sl4_q  <= sl4_d;
    eo4_q  <= eo4_d;
    sg4_q  <= sg3_q;
    zr4_q  <= (mag3_q == 79'd0);
    spv4_q <= spv3_q;
    spb4_q <= spb3_q;

    mt5_q  <= mt5_d;
    g5_q   <= g5_d;
    st5_q  <= st5_d;
    eo5_q  <= eo4_q;
    sg5_q  <= sg4_q;
    zr5_q  <= zr4_q;
    spv5_q <= spv4_q;
    spb5_q <= spb4_q;

    res6_q <= res6_d;
  end

  assign valid_o = vld_q[FMA_LAT-1];
  assign res_o   = res6_q;

  a_valid_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##FMA_LAT valid_o)
    else $error("fma beat lost in pipeline");

  a_nan_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && a_i[30:23] == 8'hFF && a_i[22:0] != 23'd0)
      |-> ##FMA_LAT (res_o == QNAN_BITS))
    else $error("NaN operand did not give quiet NaN");

endmodule
`default_nettype wire

// ----- src/float32_cosine_poly.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// float32_cosine_poly
// Binary32 cosine: range reduction by pi in three fused steps, odd sine
// polynomial of degree 9, sign fix from the parity of the quotient.
// ---------------------------------------------------------------------------
// The datapath is a chain of 13 dependent fused multiply-adds of seven
// stages each, plus the output register, from start_i to done_o.
// Throughput: one beat per cycle; busy_o is always low.
// Reset clears only the valid bits; done_o stays low after reset until
// the first accepted beat has passed through. The receiver cannot stall.
module float32_cosine_poly
  import cosp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [31:0] x_bits_i,
  output logic        done_o,
  output logic [31:0] y_bits_o,
  output logic        out_of_range_o
);

  localparam int TOTAL_LAT = NUM_OPS * FMA_LAT + 1;

  logic [31:0]      op_a [NUM_OPS];
  logic [31:0]      op_b [NUM_OPS];
  logic [31:0]      op_c [NUM_OPS];
  logic [31:0]      res  [NUM_OPS];
  logic [NUM_OPS:0] vld;

  logic [31:0] r0;
  logic        flag0;
  logic [31:0] r_d4, n_d1, n_d2, r2_d1, r2_d2, r2_d3, r_d5;
  logic        odd_d, flag_d;

  assign busy_o = 1'b0;
  assign vld[0] = start_i;
  assign r0     = {1'b0, x_bits_i[30:0]};
  assign flag0  = (x_bits_i[30:0] >= RANGE_BITS);

  for (genvar g = 0; g < NUM_OPS; g++) begin : g_op
    cosp_fma u_fma (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .a_i     (op_a[g]),
      .b_i     (op_b[g]),
      .c_i     (op_c[g]),
      .valid_o (vld[g+1]),
      .res_o   (res[g])
    );
  end

  cosp_delay #(.WIDTH(32), .DEPTH(4 * FMA_LAT)) u_dly_r4 (
    .clk_i(clk_i), .d_i(r0), .q_o(r_d4));
  cosp_delay #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_n1 (
    .clk_i(clk_i), .d_i(res[3]), .q_o(n_d1));
  cosp_delay #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_n2 (
    .clk_i(clk_i), .d_i(n_d1), .q_o(n_d2));
  cosp_delay #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_s1 (
    .clk_i(clk_i), .d_i(res[7]), .q_o(r2_d1));
  cosp_delay #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_s2 (
    .clk_i(clk_i), .d_i(r2_d1), .q_o(r2_d2));
  cosp_delay #(.WIDTH(32), .DEPTH(FMA_LAT)) u_dly_s3 (
    .clk_i(clk_i), .d_i(r2_d2), .q_o(r2_d3));
  cosp_delay #(.WIDTH(32), .DEPTH(5 * FMA_LAT)) u_dly_r5 (
    .clk_i(clk_i), .d_i(res[6]), .q_o(r_d5));
  cosp_delay #(.WIDTH(1), .DEPTH(11 * FMA_LAT)) u_dly_odd (
    .clk_i(clk_i), .d_i(res[1][0]), .q_o(odd_d));
  cosp_delay #(.WIDTH(1), .DEPTH(13 * FMA_LAT)) u_dly_flag (
    .clk_i(clk_i), .d_i(flag0), .q_o(flag_d));

  // Adds and multiplies also use their own cosp_fma instances: a+b = a*1+b, a*b = a*b+(-0).
  always_comb begin
    op_a[0]  = r0;        op_b[0]  = ONE_BITS; op_c[0]  = HALF_PI;
    op_a[1]  = INV_PI;    op_b[1]  = res[0];   op_c[1]  = SHIFT_C;
    op_a[2]  = res[1];    op_b[2]  = ONE_BITS; op_c[2]  = NEG_SHIFT;
    op_a[3]  = res[2];    op_b[3]  = ONE_BITS; op_c[3]  = NEG_HALF;
    op_a[4]  = NEG_PI_HI; op_b[4]  = res[3];   op_c[4]  = r_d4;
    op_a[5]  = NEG_PI_MID; op_b[5] = n_d1;     op_c[5]  = res[4];
    op_a[6]  = NEG_PI_LO; op_b[6]  = n_d2;     op_c[6]  = res[5];
    op_a[7]  = res[6];    op_b[7]  = res[6];   op_c[7]  = NEG_ZERO;
    op_a[8]  = POLY_C3;   op_b[8]  = res[7];   op_c[8]  = POLY_C2;
    op_a[9]  = res[8];    op_b[9]  = r2_d1;    op_c[9]  = POLY_C1;
    op_a[10] = res[9];    op_b[10] = r2_d2;    op_c[10] = POLY_C0;
    op_a[11] = res[10];   op_b[11] = r2_d3;    op_c[11] = NEG_ZERO;
    op_a[12] = res[11];   op_b[12] = r_d5;     op_c[12] = r_d5;
  end

  logic        done_q;
  logic [31:0] y_q;
  logic        oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NUM_OPS];
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= res[NUM_OPS-1] ^ {odd_d, 31'd0};
    oor_q <= flag_d;
  end

  assign done_o         = done_q;
  assign y_bits_o       = y_q;
  assign out_of_range_o = oor_q;

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##TOTAL_LAT done_o)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TOTAL_LAT))
    else $error("result without an accepted beat");

  a_in_range_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !out_of_range_o) |-> (y_bits_o[30:23] != 8'hFF))
    else $error("in-range input gave infinity or NaN");

endmodule
`default_nettype wire

// ----- bench/float32_cosine_poly_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// float32_cosine_poly_tb
// Self-checking bench for the binary32 cosine pipeline. Angles go in as
// directed corner values and then as random beats with random gaps. Each
// beat is predicted bit for bit by a model that forms every binary32
// operation in double precision, with one rounding for the fused steps.
// The model's results are compared with each done_o beat, in order.
// ---------------------------------------------------------------------------
module float32_cosine_poly_tb
  import cosp_pkg::*;
;

  localparam int LATENCY = 13 * FMA_LAT + 1;
  localparam int NUM_RANDOM = 930;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        out_of_range;
  } cos_result_t;

  // Exact power of two as a double, for k in the normal double range.
  function automatic real pow2(input int k);
    logic [10:0] e;
    e = 11'(k + 1023);
    return $bitstoreal({1'b0, e, 52'd0});
  endfunction

  function automatic real f32_to_real(input logic [31:0] v);
    real mag;
    if (v[30:23] == 8'hFF) begin
      if (v[22:0] != 0) return $bitstoreal(64'h7FF8000000000000);
      return v[31] ? $bitstoreal(64'hFFF0000000000000) : $bitstoreal(64'h7FF0000000000000);
    end
    if (v[30:23] == 8'h00) mag = real'(v[22:0]) * pow2(-149);
    else mag = real'({1'b1, v[22:0]}) * pow2(int'(v[30:23]) - 150);
    return v[31] ? -mag : mag;
  endfunction

  // Rounds a double to binary32, nearest-even, with NaNs made quiet.
  function automatic logic [31:0] real_to_f32(input real d);
    logic [63:0] db, sig, q, rem, half;
    logic [31:0] res;
    int          fe, sh;
    db = $realtobits(d);
    if (db[62:52] == 11'h7FF) begin
      if (db[51:0] != 0) return QNAN_BITS;
      return {db[63], 31'h7F800000};
    end
    if (db[62:0] == 0) return {db[63], 31'd0};
    sig = {11'd0, 1'b1, db[51:0]};
    fe  = int'(db[62:52]) - 1023 + 127;
    sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
    if (sh > 54) sh = 54;
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (fe >= 1) res = 32'((fe - 1) << 23) + q[31:0];
    else res = q[31:0];
    if (res >= 32'h7F800000) res = 32'h7F800000;
    return {db[63], res[30:0]};
  endfunction

  function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  // a*b + c rounded once: the exact product plus c, rounded to odd in
  // double so that the final rounding to binary32 is correct.
  function automatic logic [31:0] f_fma(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    real         p, cd, s, bb, err;
    logic [63:0] sb;
    p  = f32_to_real(a) * f32_to_real(b);
    cd = f32_to_real(c);
    s  = p + cd;
    if (s != s) return QNAN_BITS;
    if (s - s != 0.0) return real_to_f32(s);
    bb  = s - p;
    err = (p - (s - bb)) + (cd - bb);
    sb  = $realtobits(s);
    if (err != 0.0 && !sb[0]) begin
      if ((err > 0.0) == (s > 0.0)) sb = sb + 1;
      else sb = sb - 1;
      s = $bitstoreal(sb);
    end
    return real_to_f32(s);
  endfunction

  function automatic cos_result_t predict_cosine(input logic [31:0] x);
    cos_result_t res;
    logic [31:0] r, n, r2, y;
    logic        odd;
    r = {1'b0, x[30:0]};
    res.out_of_range = (x[30:0] >= RANGE_BITS);
    n   = f_fma(INV_PI, f_add(r, HALF_PI), SHIFT_C);
    odd = n[0];
    n   = f_add(n, NEG_SHIFT);
    n   = f_add(n, NEG_HALF);
    r   = f_fma(NEG_PI_HI, n, r);
    r   = f_fma(NEG_PI_MID, n, r);
    r   = f_fma(NEG_PI_LO, n, r);
    r2  = f_mul(r, r);
    y   = f_fma(POLY_C3, r2, POLY_C2);
    y   = f_fma(y, r2, POLY_C1);
    y   = f_fma(y, r2, POLY_C0);
    y   = f_fma(f_mul(y, r2), r, r);
    res.y_bits = {y[31] ^ odd, y[30:0]};
    return res;
  endfunction

  class cosine_scoreboard;
    cos_result_t pending[$];
    int          errors = 0;
    int          checked = 0;
    int          flagged = 0;

    function void note_angle(logic [31:0] x);
      pending.push_back(predict_cosine(x));
    endfunction

    function void check_result(logic [31:0] y, logic oor);
      cos_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result y_bits=%h out_of_range=%b with none pending", y, oor);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (oor) flagged++;
      if (y !== exp_r.y_bits) begin
        $error("y_bits: expected %h, actual %h", exp_r.y_bits, y);
        errors++;
      end
      if (oor !== exp_r.out_of_range) begin
        $error("out_of_range: expected %b, actual %b", exp_r.out_of_range, oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] x_bits_i = '0;
  logic        busy_o, done_o, out_of_range_o;
  logic [31:0] y_bits_o;

  cosine_scoreboard sb = new();

  float32_cosine_poly uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .x_bits_i      (x_bits_i),
    .done_o        (done_o),
    .y_bits_o      (y_bits_o),
    .out_of_range_o(out_of_range_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_angle(x_bits_i);
      if (done_o) sb.check_result(y_bits_o, out_of_range_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_angle(input logic [31:0] x);
    start_i  <= 1'b1;
    x_bits_i <= x;
    #1;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycle();
    start_i  <= 1'b0;
    x_bits_i <= $urandom;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_angle();
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = $urandom;
    if (pick < 60) v[30:23] = 8'($urandom_range(100, 140));
    else if (pick < 80) v[30:23] = 8'($urandom_range(141, 148));
    else if (pick < 85) v[30:23] = 8'($urandom_range(0, 1));
    return v;
  endfunction

  logic [31:0] corner_angles[] = '{
    32'h00000000, 32'h80000000, 32'h00000001, 32'h80800000, 32'h007FFFFF,
    32'h3F800000, 32'hBF800000, 32'h3FC90FDB, 32'h40490FDB, 32'hC0490FDB,
    32'h4096CBE4, 32'h3F000000, 32'h497FFFFF, 32'h49800000, 32'hC9800000,
    32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'h7F800001, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA};

  initial begin
    int wait_cycles;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (corner_angles[i]) send_angle(corner_angles[i]);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // A calm stretch in the middle keeps the pipeline full.
      if ((i < 300 || i > 500) && $urandom_range(0, 99) < 9) begin
        idle_cycle();
      end
      if (i == 650) begin
        while (sb.pending.size() != 0) idle_cycle();
      end
      send_angle(random_angle());
    end
    start_i <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("tb: %0d angles checked, %0d beyond fast range, corners incl. inf/NaN/subnormal",
             sb.checked, sb.flagged);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb: failure");
    $finish;
  end

endmodule
